>>> rtl/core/multi_slot_liveness_watchdog_unit_assert.svh
// ----------------------------------------------------------------------------
// multi slot liveness watchdog assertion macros
// shared property forms for the watchdog rtl, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_LIVENESS_WATCHDOG_UNIT_ASSERT_SVH
`define MULTI_SLOT_LIVENESS_WATCHDOG_UNIT_ASSERT_SVH

// same-cycle implication
`define MSLW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MSLW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/mslw_pkg.sv
// ----------------------------------------------------------------------------
// mslw_pkg
// constants, codes and shared types of the multi slot liveness watchdog
// ----------------------------------------------------------------------------
package mslw_pkg;

    // table size and derived index widths
    localparam int SLOTS   = 32;
    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CW = $clog2(SLOTS + 1);

    localparam logic [15:0] CHECK_INTERVAL_RESET = 16'd1000;

    // item operation codes
    localparam logic [2:0] OP_REGISTER   = 3'd0;
    localparam logic [2:0] OP_DEREGISTER = 3'd1;
    localparam logic [2:0] OP_KICK       = 3'd2;
    localparam logic [2:0] OP_TICK       = 3'd3;
    localparam logic [2:0] OP_CHECK      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_SKIPPED   = 2'd3;

    // per-slot key and limits
    typedef struct packed {
        logic [15:0] key;
        logic [31:0] warn;
        logic [31:0] fail;
    } t_slot_lims;

    // slot memory write request
    typedef struct packed {
        logic               lims_we;
        logic               kick_we;
        logic [SLOT_IW-1:0] addr;
        t_slot_lims         lims;
        logic [31:0]        kick;
    } t_mem_wr;

    // compare results of the shared slot evaluator
    typedef struct packed {
        logic key_hit;
        logic fail_hit;
        logic warn_hit;
    } t_eval_res;

endpackage

>>> rtl/core/mslw_ifs.sv
// ----------------------------------------------------------------------------
// mslw channel interfaces
// valid/ready channels for items, results and the interval register write
// ----------------------------------------------------------------------------

// input item channel
interface mslw_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] client_key;
    logic [31:0] warn_limit_ms;
    logic [31:0] fail_limit_ms;

    modport source (output valid, op, client_key, warn_limit_ms, fail_limit_ms,
                    input ready);
    modport sink   (input valid, op, client_key, warn_limit_ms, fail_limit_ms,
                    output ready);
endinterface

// result channel
interface mslw_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       healthy;
    logic       warn_seen;

    modport source (output valid, status, healthy, warn_seen, input ready);
    modport sink   (input valid, status, healthy, warn_seen, output ready);
endinterface

// check interval write channel
interface mslw_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/mslw_slot_mem.sv
// ----------------------------------------------------------------------------
// mslw_slot_mem
// slot table storage: key and limits plus last kick stamp, registered read
// ----------------------------------------------------------------------------
module mslw_slot_mem (
    input  logic                         i_clk,
    input  mslw_pkg::t_mem_wr            i_wr,
    input  logic [mslw_pkg::SLOT_IW-1:0] i_rd_addr,
    output mslw_pkg::t_slot_lims         o_lims,
    output logic [31:0]                  o_kick
);
    import mslw_pkg::*;

    t_slot_lims  r_lims_mem [SLOTS];
    logic [31:0] r_kick_mem [SLOTS];

    // write port, fields written separately
    always_ff @(posedge i_clk) begin
        if (i_wr.lims_we) begin
            r_lims_mem[i_wr.addr] <= i_wr.lims;
        end
        if (i_wr.kick_we) begin
            r_kick_mem[i_wr.addr] <= i_wr.kick;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_lims <= r_lims_mem[i_rd_addr];
        o_kick <= r_kick_mem[i_rd_addr];
    end

endmodule

>>> rtl/core/mslw_eval.sv
// ----------------------------------------------------------------------------
// mslw_eval
// shared slot evaluator: key match and wrap-safe elapsed time limit compares
// ----------------------------------------------------------------------------
module mslw_eval (
    input  logic [31:0]          i_now,
    input  logic [15:0]          i_key,
    input  mslw_pkg::t_slot_lims i_lims,
    input  logic [31:0]          i_kick,
    output mslw_pkg::t_eval_res  o_res
);
    import mslw_pkg::*;

    logic [31:0] w_elapsed;

    // elapsed time modulo 2^32
    assign w_elapsed = i_now - i_kick;

    assign o_res.key_hit  = (i_lims.key == i_key);
    assign o_res.fail_hit = (w_elapsed >= i_lims.fail);
    assign o_res.warn_hit = (w_elapsed >= i_lims.warn);

endmodule

>>> rtl/core/multi_slot_liveness_watchdog_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_liveness_watchdog_unit
// table of watched clients with register, deregister, kick, tick and check
// ----------------------------------------------------------------------------
// Timing: tick, a skipped check and an unused op code answer directly, the
// result register being loaded at the input transfer. Register, deregister
// and kick scan the slot table from slot 0 and stop at the first free or
// matching slot; a performed check always scans all SLOTS slots. The scan
// rate is set by the slot memory's single registered read port feeding one
// shared evaluator, one slot per cycle. Used flags sit in flip-flops cleared
// at reset, so no clearing pass follows reset. A new item is taken once the
// unit is idle and the result register is free or being taken in the same
// cycle.
module multi_slot_liveness_watchdog_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    mslw_item_if.sink  i_item,
    mslw_res_if.source o_res,
    mslw_cfg_if.sink   i_cfg
);
    import mslw_pkg::*;

    `include "multi_slot_liveness_watchdog_unit_assert.svh"

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state             r_state;
    logic [SLOTS-1:0]   r_used;
    logic [31:0]        r_now;
    logic [31:0]        r_last_chk;
    logic               r_checked;
    logic [15:0]        r_interval;
    logic [SLOT_CW-1:0] r_idx;
    logic               r_rd_vld;
    logic [SLOT_IW-1:0] r_rd_idx;
    logic               r_fail_acc;
    logic               r_warn_acc;
    logic               r_out_vld;
    logic [1:0]         r_status;
    logic               r_healthy;
    logic               r_warn;
    // latched item
    logic [2:0]         r_op;
    logic [15:0]        r_key;
    logic [31:0]        r_warn_lim;
    logic [31:0]        r_fail_lim;

    logic        w_in_xfer;
    logic        w_out_xfer;
    logic        w_cfg_xfer;
    logic [31:0] w_since;
    logic        w_skip;
    logic        w_slot_used;
    logic        w_reg_hit;
    logic        w_key_hit;
    logic        w_fail_now;
    logic        w_warn_now;
    logic        w_last;
    logic        w_tick_in;
    logic        w_chk_run;
    t_slot_lims  w_rd_lims;
    logic [31:0] w_rd_kick;
    t_eval_res   w_eval;
    t_mem_wr     w_wr;

    // handshakes
    assign w_in_xfer  = i_item.valid & i_item.ready;
    assign w_out_xfer = r_out_vld & o_res.ready;
    assign w_cfg_xfer = i_cfg.valid & i_cfg.ready;

    assign i_item.ready = (r_state == S_IDLE) && (!r_out_vld || o_res.ready);
    assign i_cfg.ready  = 1'b1;

    assign o_res.valid     = r_out_vld;
    assign o_res.status    = r_status;
    assign o_res.healthy   = r_healthy;
    assign o_res.warn_seen = r_warn;

    // check interval gate
    assign w_since = r_now - r_last_chk;
    assign w_skip  = r_checked && (w_since < {16'b0, r_interval});

    // accepted tick and performed check
    assign w_tick_in = w_in_xfer && (i_item.op == OP_TICK);
    assign w_chk_run = w_in_xfer && (i_item.op == OP_CHECK) && !w_skip;

    // slot storage and shared evaluator
    mslw_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (r_idx[SLOT_IW-1:0]),
        .o_lims    (w_rd_lims),
        .o_kick    (w_rd_kick)
    );

    mslw_eval u_eval (
        .i_now  (r_now),
        .i_key  (r_key),
        .i_lims (w_rd_lims),
        .i_kick (w_rd_kick),
        .o_res  (w_eval)
    );

    // per-slot decisions on the slot read last cycle
    assign w_slot_used = r_used[r_rd_idx];
    assign w_reg_hit   = (r_state == S_SCAN) && r_rd_vld && (r_op == OP_REGISTER)
                         && !w_slot_used;
    assign w_key_hit   = (r_state == S_SCAN) && r_rd_vld && w_slot_used
                         && ((r_op == OP_DEREGISTER) || (r_op == OP_KICK))
                         && w_eval.key_hit;
    assign w_fail_now  = (r_op == OP_CHECK) && w_slot_used && w_eval.fail_hit;
    assign w_warn_now  = (r_op == OP_CHECK) && w_slot_used && !w_eval.fail_hit
                         && w_eval.warn_hit;
    assign w_last      = (r_rd_idx == SLOT_IW'(SLOTS - 1));

    // memory writes: new slot or kick stamp
    always_comb begin
        w_wr.lims_we   = w_reg_hit;
        w_wr.kick_we   = w_reg_hit || (w_key_hit && (r_op == OP_KICK));
        w_wr.addr      = r_rd_idx;
        w_wr.lims.key  = r_key;
        w_wr.lims.warn = r_warn_lim;
        w_wr.lims.fail = r_fail_lim;
        w_wr.kick      = r_now;
    end

    // latched item fields
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op       <= i_item.op;
            r_key      <= i_item.client_key;
            r_warn_lim <= i_item.warn_limit_ms;
            r_fail_lim <= i_item.fail_limit_ms;
        end
    end

    // sequencer, table state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_now      <= '0;
            r_last_chk <= '0;
            r_checked  <= 1'b0;
            r_interval <= CHECK_INTERVAL_RESET;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_fail_acc <= 1'b0;
            r_warn_acc <= 1'b0;
            r_out_vld  <= 1'b0;
            r_status   <= ST_DONE;
            r_healthy  <= 1'b1;
            r_warn     <= 1'b0;
        end else begin
            if (w_cfg_xfer) begin
                r_interval <= i_cfg.data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_idx      <= '0;
                        r_rd_vld   <= 1'b0;
                        r_fail_acc <= 1'b0;
                        r_warn_acc <= 1'b0;
                        case (i_item.op)
                            OP_TICK: begin
                                r_now     <= r_now + 32'd1;
                                r_out_vld <= 1'b1;
                                r_status  <= ST_DONE;
                                r_healthy <= 1'b1;
                                r_warn    <= 1'b0;
                            end
                            OP_CHECK: begin
                                if (w_skip) begin
                                    r_out_vld <= 1'b1;
                                    r_status  <= ST_SKIPPED;
                                    r_healthy <= 1'b1;
                                    r_warn    <= 1'b0;
                                end else begin
                                    r_out_vld  <= 1'b0;
                                    r_last_chk <= r_now;
                                    r_checked  <= 1'b1;
                                    r_state    <= S_SCAN;
                                end
                            end
                            OP_REGISTER, OP_DEREGISTER, OP_KICK: begin
                                r_out_vld <= 1'b0;
                                r_state   <= S_SCAN;
                            end
                            default: begin
                                r_out_vld <= 1'b1;
                                r_status  <= ST_DONE;
                                r_healthy <= 1'b1;
                                r_warn    <= 1'b0;
                            end
                        endcase
                    end else if (w_out_xfer) begin
                        r_out_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // issue the next slot read
                    if (r_idx < SLOT_CW'(SLOTS)) begin
                        r_idx    <= r_idx + SLOT_CW'(1);
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_idx[SLOT_IW-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    // evaluate the slot read last cycle
                    if (r_rd_vld) begin
                        r_fail_acc <= r_fail_acc | w_fail_now;
                        r_warn_acc <= r_warn_acc | w_warn_now;
                        if (w_reg_hit || w_key_hit) begin
                            if (w_reg_hit) begin
                                r_used[r_rd_idx] <= 1'b1;
                            end else if (r_op == OP_DEREGISTER) begin
                                r_used[r_rd_idx] <= 1'b0;
                            end
                            r_out_vld <= 1'b1;
                            r_status  <= ST_DONE;
                            r_healthy <= 1'b1;
                            r_warn    <= 1'b0;
                            r_state   <= S_IDLE;
                        end else if (w_last) begin
                            r_out_vld <= 1'b1;
                            r_healthy <= !(r_fail_acc | w_fail_now);
                            r_warn    <= r_warn_acc | w_warn_now;
                            if (r_op == OP_REGISTER) begin
                                r_status <= ST_FULL;
                            end else if (r_op == OP_CHECK) begin
                                r_status <= ST_DONE;
                            end else begin
                                r_status <= ST_NOT_FOUND;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks on the sequencer and table state
    `MSLW_ASSERT_NOW(a_scan_out_free, r_state == S_SCAN, !r_out_vld, "result pending in scan")
    `MSLW_ASSERT_NEXT(a_tick_adv, w_tick_in, r_now == $past(r_now) + 32'd1, "tick missed")
    `MSLW_ASSERT_NEXT(a_check_flag, w_chk_run, r_checked, "check flag not set")
    `MSLW_ASSERT_NEXT(a_check_stamp, w_chk_run, r_last_chk == $past(r_now), "no stamp")
    `MSLW_ASSERT_NOW(a_unhealthy_done, !r_healthy, r_status == ST_DONE, "unhealthy not done")

endmodule
